### rtl/core/cosim_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and defaults for the cosine similarity block.
// No dependencies; every other file imports this package.
package cosim_pkg;

  localparam int ELEM_W  = 16;
  localparam int MAX_LEN = 1024;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int NORM_W  = 2 * ELEM_W - 1 + $clog2(MAX_LEN);
  localparam int DOT_W   = NORM_W + 1;
  localparam int SCORE_W = 16;
  localparam int FRAC_W  = SCORE_W - 1;
  localparam int SRCH_W  = 2 * DOT_W + 2 * SCORE_W;
  localparam int MUL_STEPS = DOT_W;
  localparam int CNT_W   = $clog2(MUL_STEPS);
  localparam int BIT_W   = $clog2(SCORE_W);
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [DOT_W-1:0]   DOT_MAX   = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0]   DOT_MIN   = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [NORM_W-1:0]         NORM_MAX  = {NORM_W{1'b1}};

  // finished sums of one vector pair, handed from accumulator to score unit
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
  } cosim_sums_t;

endpackage

### rtl/core/cosim_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for element pairs in and scores out.
// Depends on cosim_pkg for field widths.
interface cosim_in_if
  import cosim_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] a_elem;
  logic signed [ELEM_W-1:0] b_elem;
  logic                     last;

  modport source (output valid, output a_elem, output b_elem, output last, input ready);
  modport sink   (input valid, input a_elem, input b_elem, input last, output ready);
endinterface

interface cosim_out_if
  import cosim_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      is_match;
  logic                      zero_norm;

  modport source (output valid, output score, output is_match, output zero_norm, input ready);
  modport sink   (input valid, input score, input is_match, input zero_norm, output ready);
endinterface

### rtl/core/cosim_front.sv
`timescale 1ns / 1ps
// Front end: takes element pairs, registers the three products and keeps
// saturating dot and norm sums. Depends on cosim_pkg and cosim_in_if.
module cosim_front
  import cosim_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cosim_in_if.sink    elem,
  input  logic        q_full,
  output logic        push,
  output cosim_sums_t push_sums
);

  logic signed [PROD_W-1:0] prod_ab, prod_aa, prod_bb;
  logic                     s1_valid, s1_last, s1_adv, accept;
  logic signed [PROD_W-1:0] s1_p;
  logic [PROD_W-2:0]        s1_pa, s1_pb;

  logic signed [DOT_W-1:0]  dot;
  logic [NORM_W-1:0]        norm_a, norm_b;
  logic signed [DOT_W:0]    dot_wide;
  logic [NORM_W:0]          na_wide, nb_wide;
  logic signed [DOT_W-1:0]  dot_sat;
  logic [NORM_W-1:0]        na_sat, nb_sat;

  assign prod_ab = elem.a_elem * elem.b_elem;
  assign prod_aa = elem.a_elem * elem.a_elem;
  assign prod_bb = elem.b_elem * elem.b_elem;

  // a request with last needs a free queue slot before it can fold in
  assign s1_adv     = s1_valid && (!s1_last || !q_full);
  assign elem.ready = !s1_valid || s1_adv;
  assign accept     = elem.valid && elem.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= elem.last;
      s1_p    <= prod_ab;
      s1_pa   <= prod_aa[PROD_W-2:0];
      s1_pb   <= prod_bb[PROD_W-2:0];
    end
  end

  always_comb begin
    dot_wide = {dot[DOT_W-1], dot} + (DOT_W+1)'(s1_p);
    na_wide  = {1'b0, norm_a} + (NORM_W+1)'(s1_pa);
    nb_wide  = {1'b0, norm_b} + (NORM_W+1)'(s1_pb);
    if (dot_wide[DOT_W] != dot_wide[DOT_W-1]) begin
      dot_sat = dot_wide[DOT_W] ? DOT_MIN : DOT_MAX;
    end else begin
      dot_sat = dot_wide[DOT_W-1:0];
    end
    na_sat = na_wide[NORM_W] ? NORM_MAX : na_wide[NORM_W-1:0];
    nb_sat = nb_wide[NORM_W] ? NORM_MAX : nb_wide[NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot    <= '0;
      norm_a <= '0;
      norm_b <= '0;
    end else if (s1_adv) begin
      dot    <= s1_last ? '0 : dot_sat;
      norm_a <= s1_last ? '0 : na_sat;
      norm_b <= s1_last ? '0 : nb_sat;
    end
  end

  assign push             = s1_adv && s1_last;
  assign push_sums.dot    = dot_sat;
  assign push_sums.norm_a = na_sat;
  assign push_sums.norm_b = nb_sat;

endmodule

### rtl/core/cosim_queue.sv
`timescale 1ns / 1ps
// Short register queue of finished sums between accumulator and score unit.
// Depends on cosim_pkg for the entry type.
module cosim_queue
  import cosim_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cosim_sums_t push_sums,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output cosim_sums_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cosim_sums_t   slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/core/cosim_back.sv
`timescale 1ns / 1ps
// Score unit: shift-add multiplies for dot squared and norm_a * norm_b, then a bit-by-bit
// search for the score magnitude, threshold compare and output register. Depends on cosim_pkg, cosim_out_if.
module cosim_back
  import cosim_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [SCORE_W-1:0] thr,
  input  logic                      q_valid,
  input  cosim_sums_t               q_head,
  output logic                      q_pop,
  cosim_out_if.source               res
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_SRCH_A = 3'd2;
  localparam logic [2:0] ST_SRCH_B = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]            st;
  logic [CNT_W-1:0]      cnt;
  logic [BIT_W-1:0]      k;
  logic                  neg, zero;
  logic [2*NORM_W-1:0]   mc_n, acc_n, acc_n_next;
  logic [NORM_W-1:0]     mp_n;
  logic [2*DOT_W-1:0]    mc_d, acc_d, acc_d_next;
  logic [DOT_W-1:0]      mp_d, dot_abs;
  logic [SRCH_W-1:0]     pk, u_acc, s_acc, x_acc, cand, lim;
  logic                  fit, out_free;
  logic [SCORE_W-1:0]    m;
  logic signed [SCORE_W-1:0] score_c;

  assign q_pop    = (st == ST_IDLE) && q_valid;
  assign out_free = !res.valid || res.ready;
  assign dot_abs  = q_head.dot[DOT_W-1] ? DOT_W'(-q_head.dot) : DOT_W'(q_head.dot);

  always_comb begin
    acc_n_next = acc_n + (mp_n[0] ? mc_n : '0);
    acc_d_next = acc_d + (mp_d[0] ? mc_d : '0);
    // m^2 * na * nb must not pass dot^2 * 2^30
    lim  = {{(SRCH_W-2*DOT_W-2*FRAC_W){1'b0}}, acc_d, {(2*FRAC_W){1'b0}}};
    cand = s_acc + x_acc;
    fit  = (cand <= lim);
    if (zero) begin
      score_c = '0;
    end else if (neg) begin
      score_c = m[SCORE_W-1] ? SCORE_MIN : -$signed(m);
    end else begin
      score_c = m[SCORE_W-1] ? SCORE_MAX : $signed(m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      res.valid <= 1'b0;
    end else begin
      // in ST_FIN the output register is reloaded below whenever it drains
      if (res.valid && res.ready && st != ST_FIN) begin
        res.valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (q_valid) begin
            zero  <= (q_head.norm_a == '0) || (q_head.norm_b == '0);
            neg   <= q_head.dot[DOT_W-1];
            mc_n  <= (2*NORM_W)'(q_head.norm_a);
            mp_n  <= q_head.norm_b;
            mc_d  <= (2*DOT_W)'(dot_abs);
            mp_d  <= dot_abs;
            acc_n <= '0;
            acc_d <= '0;
            cnt   <= '0;
            m     <= '0;
            s_acc <= '0;
            u_acc <= '0;
            k     <= BIT_W'(SCORE_W - 1);
            st    <= ((q_head.norm_a == '0) || (q_head.norm_b == '0)) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          acc_n <= acc_n_next;
          acc_d <= acc_d_next;
          mc_n  <= mc_n << 1;
          mc_d  <= mc_d << 1;
          mp_n  <= mp_n >> 1;
          mp_d  <= mp_d >> 1;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            // first trial bit weighs (2^15)^2
            pk <= {{(SRCH_W-2*NORM_W-2*FRAC_W){1'b0}}, acc_n_next, {(2*FRAC_W){1'b0}}};
            st <= ST_SRCH_A;
          end
        end
        ST_SRCH_A: begin
          x_acc <= u_acc + pk;
          st    <= ST_SRCH_B;
        end
        ST_SRCH_B: begin
          if (fit) begin
            s_acc <= cand;
            m[k]  <= 1'b1;
            u_acc <= (u_acc >> 1) + pk;
          end else begin
            u_acc <= u_acc >> 1;
          end
          pk <= pk >> 2;
          if (k == '0) begin
            st <= ST_FIN;
          end else begin
            k  <= k - 1'b1;
            st <= ST_SRCH_A;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            res.valid     <= 1'b1;
            res.score     <= score_c;
            res.is_match  <= (score_c >= thr);
            res.zero_norm <= zero;
            st            <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_zero_score: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.zero_norm |-> res.score == '0)
    else $error("zero norm result with non-zero score");
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    st == ST_SRCH_A |-> s_acc <= lim)
    else $error("accepted partial square beyond limit");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.score) && $stable(res.is_match)
      && $stable(res.zero_norm))
    else $error("result request changed while waiting");

endmodule

### rtl/core/cosine_similarity_threshold.sv
`timescale 1ns / 1ps
// Streaming cosine similarity with match threshold. Element pairs (signed Q1.15)
// are taken one per cycle unless the input stalls; the request marked last closes
// the vector; one result per vector gives the score in signed Q1.15 (saturated),
// a match flag against match_threshold and a zero-norm flag. The score unit runs
// shift-add multiplies for the squared dot and the norm product, then a bit-by-bit
// search for the 16-bit score magnitude. A queue of QUEUE_DEPTH finished vectors
// sits in front of it, so input only stalls while that queue is full, when vectors
// arrive faster than the score unit drains them. Depends on cosim_pkg and cosim_ifs.
module cosine_similarity_threshold
  import cosim_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  cosim_in_if.sink                  elem_in,
  cosim_out_if.source               result_out,
  input  logic                      cfg_wr_en,
  input  logic signed [SCORE_W-1:0] cfg_wr_data
);

  logic signed [SCORE_W-1:0] match_threshold;
  logic                      push, q_full, q_valid, q_pop;
  cosim_sums_t               push_sums, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_threshold <= '0;
    end else if (cfg_wr_en) begin
      match_threshold <= cfg_wr_data;
    end
  end

  cosim_front u_front (
    .clk       (clk),
    .rst       (rst),
    .elem      (elem_in),
    .q_full    (q_full),
    .push      (push),
    .push_sums (push_sums)
  );

  cosim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_sums  (push_sums),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  cosim_back u_back (
    .clk     (clk),
    .rst     (rst),
    .thr     (match_threshold),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (result_out)
  );

endmodule

### verif/cosine_similarity_threshold_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for cosine_similarity_threshold: streams element pairs, predicts
// every score in a scoreboard and checks each result request as it leaves the block.
// Depends on cosim_pkg, the channel interfaces in cosim_ifs and the block itself.
module cosine_similarity_threshold_tb
  import cosim_pkg::*;
;

  localparam int SETTLE_CYCLES   = 100;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int OUT_HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS     = 110;
  localparam int REPORT_LIMIT    = 10;

  localparam longint DOT_TOP    = (longint'(1) << (DOT_W - 1)) - 1;
  localparam longint DOT_BOTTOM = -DOT_TOP - 1;
  localparam longint NORM_TOP   = (longint'(1) << NORM_W) - 1;

  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_SAME,
    SHAPE_NEGATED,
    SHAPE_ZERO_A,
    SHAPE_ZERO_B,
    SHAPE_NEAR
  } shape_t;

  typedef struct {
    score_t score;
    logic   is_match;
    logic   zero_norm;
  } cosine_result_t;

  class similarity_scoreboard;
    score_t         threshold;
    longint         dot_run;
    longint         norm_a_run;
    longint         norm_b_run;
    cosine_result_t score_queue[$];
    int             mismatches;

    function new();
      threshold  = '0;
      dot_run    = 0;
      norm_a_run = 0;
      norm_b_run = 0;
      mismatches = 0;
    endfunction

    // largest m <= 2^15 with m^2 * na * nb <= dot^2 * 2^30, done exactly
    function longint cosine_magnitude(longint dot_abs);
      bit [127:0]  lim;
      bit [127:0]  prod;
      bit [127:0]  wide_mid;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lim  = 128'(dot_abs);
      lim  = (lim * lim) << 30;
      prod = 128'(norm_a_run);
      prod = prod * 128'(norm_b_run);
      lo   = 0;
      hi   = 32768;
      while (lo < hi) begin
        mid      = (lo + hi + 1) / 2;
        wide_mid = 128'(mid);
        if (prod * wide_mid * wide_mid <= lim) lo = mid;
        else hi = mid - 1;
      end
      return longint'(lo);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t: %s", $time, what);
    endfunction

    function void note_pair(elem_t a, elem_t b, logic last);
      longint         p;
      longint         pa;
      longint         pb;
      longint         m;
      cosine_result_t r;
      p  = longint'(a) * longint'(b);
      pa = longint'(a) * longint'(a);
      pb = longint'(b) * longint'(b);
      // sums clip at the ends of their widths rather than wrap
      if (p > 0 && dot_run > DOT_TOP - p) dot_run = DOT_TOP;
      else if (p < 0 && dot_run < DOT_BOTTOM - p) dot_run = DOT_BOTTOM;
      else dot_run += p;
      norm_a_run = (pa > NORM_TOP - norm_a_run) ? NORM_TOP : norm_a_run + pa;
      norm_b_run = (pb > NORM_TOP - norm_b_run) ? NORM_TOP : norm_b_run + pb;
      if (!last) return;
      r.zero_norm = (norm_a_run == 0 || norm_b_run == 0);
      if (r.zero_norm) begin
        r.score = '0;
      end else if (dot_run >= 0) begin
        m       = cosine_magnitude(dot_run);
        r.score = score_t'((m > longint'(SCORE_MAX)) ? longint'(SCORE_MAX) : m);
      end else begin
        m       = cosine_magnitude(-dot_run);
        r.score = score_t'(-m);
      end
      r.is_match = (r.score >= threshold);
      score_queue.push_back(r);
      dot_run    = 0;
      norm_a_run = 0;
      norm_b_run = 0;
    endfunction

    function void check_result(score_t score, logic is_match, logic zero_norm);
      cosine_result_t want;
      if (score_queue.size() == 0) begin
        flag($sformatf("unexpected result score=%0d match=%0b zero=%0b",
                       score, is_match, zero_norm));
        return;
      end
      want = score_queue.pop_front();
      if (score !== want.score || is_match !== want.is_match || zero_norm !== want.zero_norm)
        flag($sformatf("expected score=%0d match=%0b zero=%0b, got score=%0d match=%0b zero=%0b",
                       want.score, want.is_match, want.zero_norm,
                       score, is_match, zero_norm));
    endfunction

    function int outstanding();
      return score_queue.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst;
  logic   cfg_wr_en;
  score_t cfg_wr_data;

  cosim_in_if  elem_in ();
  cosim_out_if result_out ();

  cosine_similarity_threshold dut (
    .clk         (clk),
    .rst         (rst),
    .elem_in     (elem_in),
    .result_out  (result_out),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  similarity_scoreboard scores;
  bit          steady_tail   = 1'b0;
  bit          hold_results  = 1'b0;
  bit          src_gappy     = 1'b0;
  int unsigned items_sent    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** cosine_similarity_threshold: FAILED **");
    $finish;
  end

  // result side: checks each accepted request, then picks next cycle's ready
  initial begin : result_sink
    int unsigned gap_left;
    int unsigned stretch_left;
    int unsigned hold_left;
    bit          stretch_stalls;
    gap_left       = 0;
    stretch_left   = 0;
    hold_left      = 0;
    stretch_stalls = 1'b0;
    result_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_out.valid && result_out.ready)
        scores.check_result(result_out.score, result_out.is_match, result_out.zero_norm);
      if (hold_results) begin
        hold_results = 1'b0;
        hold_left    = OUT_HOLD_CYCLES;
      end
      if (stretch_left == 0) begin
        stretch_left   = $urandom_range(20, 300);
        stretch_stalls = ($urandom_range(0, 2) != 0);
      end
      stretch_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_out.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        result_out.ready <= 1'b0;
      end else if (!steady_tail && stretch_stalls && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 10) - 1;
        result_out.ready <= 1'b0;
      end else begin
        result_out.ready <= 1'b1;
      end
    end
  end

  task automatic send_pair(elem_t a, elem_t b, logic last);
    if (!steady_tail && src_gappy && $urandom_range(0, 5) == 0) begin
      elem_in.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    elem_in.valid  <= 1'b1;
    elem_in.a_elem <= a;
    elem_in.b_elem <= b;
    elem_in.last   <= last;
    do @(posedge clk); while (!elem_in.ready);
    scores.note_pair(a, b, last);
    items_sent++;
  endtask

  task automatic send_vector(ref elem_t va[$], ref elem_t vb[$]);
    src_gappy = ($urandom_range(0, 2) != 0);
    foreach (va[i]) send_pair(va[i], vb[i], i == va.size() - 1);
  endtask

  function automatic elem_t random_elem(int unsigned amp);
    case ($urandom_range(0, 9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3, 4:    return elem_t'($urandom);
      default: return elem_t'(int'($urandom_range(0, 2 * amp)) - int'(amp));
    endcase
  endfunction

  task automatic build_vector(shape_t shape, int len, ref elem_t va[$], ref elem_t vb[$]);
    int unsigned amp;
    int          noise;
    int          near;
    elem_t       x;
    elem_t       y;
    va.delete();
    vb.delete();
    case ($urandom_range(0, 3))
      0:       amp = 3;
      1:       amp = 200;
      2:       amp = 8000;
      default: amp = 32767;
    endcase
    noise = amp / 16 + 1;
    for (int i = 0; i < len; i++) begin
      x = random_elem(amp);
      case (shape)
        SHAPE_SAME:    y = x;
        SHAPE_NEGATED: y = -x;
        SHAPE_ZERO_A: begin
          y = x;
          x = '0;
        end
        SHAPE_ZERO_B:  y = '0;
        SHAPE_NEAR: begin
          near = int'(x) + int'($urandom_range(0, 2 * noise)) - noise;
          if (near > int'(ELEM_MAX)) near = int'(ELEM_MAX);
          if (near < int'(ELEM_MIN)) near = int'(ELEM_MIN);
          y = elem_t'(near);
        end
        default:       y = random_elem(amp);
      endcase
      va.push_back(x);
      vb.push_back(y);
    end
  endtask

  task automatic wait_drained();
    while (scores.outstanding() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(score_t value);
    elem_in.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scores.threshold = value;
  endtask

  task automatic run_corner_vectors();
    src_gappy = 1'b0;
    send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
    send_pair(0, 0, 1'b1);
    send_pair(0, 12345, 1'b1);
    send_pair(-12345, 0, 1'b1);
    // orthogonal pair: dot product zero, norms not
    send_pair(1, 1, 1'b0);
    send_pair(1, -1, 1'b1);
    send_pair(1, ELEM_MAX, 1'b1);
    send_pair(0, 5, 1'b0);
    send_pair(0, -7, 1'b1);
    send_pair(-1, -1, 1'b0);
    send_pair(-1, 1, 1'b0);
    send_pair(1, 1, 1'b1);
    send_pair(3, -4, 1'b0);
    send_pair(4, 3, 1'b0);
    send_pair(-1, -1, 1'b1);
    send_pair(elem_t'(16'h5555), elem_t'(16'hAAAA), 1'b1);
    send_pair(elem_t'(16'hAAAA), elem_t'(16'h5555), 1'b1);
  endtask

  task automatic run_random_vectors(int unsigned count);
    elem_t       va[$];
    elem_t       vb[$];
    shape_t      shape;
    int          len;
    int unsigned r;
    int unsigned stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0:       shape = SHAPE_SAME;
        1:       shape = SHAPE_NEGATED;
        2:       shape = SHAPE_ZERO_A;
        3:       shape = SHAPE_ZERO_B;
        4, 5:    shape = SHAPE_NEAR;
        default: shape = SHAPE_RANDOM;
      endcase
      r = $urandom_range(0, 19);
      if (r < 15) len = $urandom_range(1, 6);
      else if (r < 19) len = $urandom_range(7, 30);
      else len = $urandom_range(31, 120);
      build_vector(shape, len, va, vb);
      send_vector(va, vb);
    end
  endtask

  // results held back for a long stretch while short vectors keep coming
  task automatic squeeze_input();
    elem_t  va[$];
    elem_t  vb[$];
    shape_t shape;
    hold_results = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 1) != 0) shape = SHAPE_RANDOM;
      else shape = SHAPE_NEAR;
      build_vector(shape, $urandom_range(1, 2), va, vb);
      send_vector(va, vb);
    end
  endtask

  initial begin : stimulus
    scores = new();
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    elem_in.valid  <= 1'b0;
    elem_in.a_elem <= '0;
    elem_in.b_elem <= '0;
    elem_in.last   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_corner_vectors();
    set_threshold(SCORE_MIN);
    run_random_vectors(PHASE_ITEMS);
    set_threshold(SCORE_MAX);
    run_random_vectors(PHASE_ITEMS);
    set_threshold(16384);
    run_random_vectors(PHASE_ITEMS);
    set_threshold(score_t'($urandom));
    run_random_vectors(PHASE_ITEMS);
    set_threshold(-8000);
    run_random_vectors(PHASE_ITEMS);
    set_threshold(score_t'($urandom));
    squeeze_input();
    run_random_vectors(PHASE_ITEMS);
    set_threshold('0);
    steady_tail = 1'b1;
    run_random_vectors(PHASE_ITEMS);

    elem_in.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scores.mismatches == 0 && scores.outstanding() == 0)
      $display("** cosine_similarity_threshold: PASSED **");
    else
      $display("** cosine_similarity_threshold: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/core/cosim_pkg.sv
rtl/core/cosim_ifs.sv
rtl/core/cosim_front.sv
rtl/core/cosim_queue.sv
rtl/core/cosim_back.sv
rtl/core/cosine_similarity_threshold.sv
verif/cosine_similarity_threshold_tb.sv
